// File: rtl/dedup_set_store_defines.svh
// Assertion macros shared by the set store RTL.
// Depends on nothing; users supply clk and arst_n in the including scope.
`ifndef DEDUP_SET_STORE_DEFINES_SVH
`define DEDUP_SET_STORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dedup_set_store: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DSS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dedup_set_store: check failed");

`endif

// File: rtl/dss_pkg.sv
// Shared types and codes for the deduplicating set store.
// No dependencies; imported by dedup_set_store and tb_dedup_set_store.
`timescale 1ns / 1ps

package dss_pkg;

	localparam int SET_CAPACITY_DEF = 16;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;

	localparam logic [2:0] STATUS_DONE    = 3'd0;
	localparam logic [2:0] STATUS_PRESENT = 3'd1;
	localparam logic [2:0] STATUS_ABSENT  = 3'd2;
	localparam logic [2:0] STATUS_FULL    = 3'd3;
	localparam logic [2:0] STATUS_RANGE   = 3'd4;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] value;
		logic [3:0]         index;
	} req_word_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [4:0]         element_count;
		logic signed [31:0] element;
	} rsp_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_RESOLVE,
		ST_SHIFT,
		ST_POP,
		ST_RDATA,
		ST_FINISH
	} state_t;

endpackage

// File: rtl/dss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used by dedup_set_store for the entry array.
`timescale 1ns / 1ps

module dss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/dedup_set_store.sv
// Top level of the deduplicating set store: sequencer, count and result register.
// Depends on dss_pkg, dss_ram and dedup_set_store_defines.svh.
`timescale 1ns / 1ps
//
// Usage:
// A request word (kind, value, index) is taken on req when req_valid and
// req_ready are both high. Kind 0 appends value unless it is already stored or
// the store is full, kind 1 removes the first equal entry and closes the gap,
// kind 2 reads the entry at index. Exactly one response word (status,
// element_count, element) follows on rsp under the same valid/ready rule.
// Entries live in a single-port-read RAM, so the search walks the stored
// entries one per cycle and a delete moves the later entries down one per
// cycle. The block handles one word at a time: req_ready is high only
// between words. A finished response waits in the output register; the next
// request can be taken while it waits, but that request cannot finish until
// rsp is free. Reset empties the store (count zero) and drops any pending
// response; the RAM contents are not cleared, since only entries below the
// count are read.
//

module dedup_set_store
	import dss_pkg::*;
#(
	parameter int SET_CAPACITY = SET_CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp
);

	`include "dedup_set_store_defines.svh"

	localparam int AW = $clog2(SET_CAPACITY);
	localparam int CW = $clog2(SET_CAPACITY + 1);
	localparam int IW = (CW > 4) ? CW : 4;

	state_t            state_q, state_d;
	req_word_t         item_q;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     ptr_q, ptr_d;
	logic [2:0]        status_q, status_d;
	logic signed [31:0] elem_q, elem_d;
	logic              rsp_valid_q;
	rsp_word_t         rsp_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [31:0]       ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [31:0]       ram_rdata;

	logic [CW:0]       ptr_p1, ptr_p2, count_x;
	logic              more1, more2, match, empty, full, idx_oor, rsp_load;

	dss_ram #(
		.WIDTH(32),
		.DEPTH(SET_CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign ptr_p1  = {1'b0, ptr_q} + (CW+1)'(1);
	assign ptr_p2  = {1'b0, ptr_q} + (CW+1)'(2);
	assign count_x = {1'b0, count_q};
	assign more1   = ptr_p1 < count_x;
	assign more2   = ptr_p2 < count_x;
	assign match   = ram_rdata == $unsigned(item_q.value);
	assign empty   = count_q == '0;
	assign full    = count_q == CW'(SET_CAPACITY);
	assign idx_oor = IW'(item_q.index) >= IW'(count_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (item_q.kind)
					KIND_INSERT, KIND_DELETE: state_d = empty ? ST_RESOLVE : ST_SCAN;
					KIND_READ:                state_d = idx_oor ? ST_FINISH : ST_RDATA;
					default:                  state_d = ST_FINISH;
				endcase
			end
			ST_SCAN: begin
				if (match) begin
					if (item_q.kind == KIND_INSERT) begin
						state_d = ST_FINISH;
					end else begin
						state_d = more1 ? ST_SHIFT : ST_POP;
					end
				end else begin
					state_d = more1 ? ST_SCAN : ST_RESOLVE;
				end
			end
			ST_RESOLVE: state_d = ST_FINISH;
			ST_SHIFT:   state_d = more2 ? ST_SHIFT : ST_POP;
			ST_POP:     state_d = ST_FINISH;
			ST_RDATA:   state_d = ST_FINISH;
			ST_FINISH: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// Datapath controls and next values.
	always_comb begin
		req_ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = AW'(ptr_q);
		ram_wdata = ram_rdata;
		ram_raddr = AW'(ptr_p1);
		ptr_d     = ptr_q;
		count_d   = count_q;
		status_d  = status_q;
		elem_d    = elem_q;
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_DISPATCH: begin
				ptr_d    = '0;
				status_d = STATUS_DONE;
				elem_d   = '0;
				if (item_q.kind == KIND_READ) begin
					ram_raddr = AW'(item_q.index);
					if (idx_oor) begin
						status_d = STATUS_RANGE;
					end
				end else begin
					ram_raddr = '0;
				end
			end
			ST_SCAN: begin
				// Compare the word read last cycle while fetching the next one.
				if (match) begin
					if (item_q.kind == KIND_INSERT) begin
						status_d = STATUS_PRESENT;
					end
				end else if (more1) begin
					ptr_d = CW'(ptr_p1);
				end
			end
			ST_RESOLVE: begin
				if (item_q.kind == KIND_INSERT) begin
					if (full) begin
						status_d = STATUS_FULL;
					end else begin
						ram_we    = 1'b1;
						ram_waddr = AW'(count_q);
						ram_wdata = $unsigned(item_q.value);
						count_d   = count_q + CW'(1);
					end
				end else begin
					status_d = STATUS_ABSENT;
				end
			end
			ST_SHIFT: begin
				// The entry after ptr arrived this cycle; move it down one place.
				ram_we    = 1'b1;
				ram_waddr = AW'(ptr_q);
				ram_raddr = AW'(ptr_p2);
				ptr_d     = CW'(ptr_p1);
			end
			ST_POP: begin
				count_d = count_q - CW'(1);
			end
			ST_RDATA: begin
				elem_d = $signed(ram_rdata);
			end
			ST_FINISH: begin
				rsp_load = !rsp_valid_q || rsp_ready;
			end
			default: begin
				ptr_d = ptr_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ptr_q   <= ptr_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		elem_q   <= elem_d;
		if (req_valid && req_ready) begin
			item_q <= req;
		end
		if (rsp_load) begin
			rsp_q.status        <= status_q;
			rsp_q.element_count <= 5'(count_q);
			rsp_q.element       <= elem_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`DSS_ASSERT_NOW(a_count_cap, 1'b1, count_q <= CW'(SET_CAPACITY))
	`DSS_ASSERT_NEXT(a_accept_dispatch, req_valid && req_ready, state_q == ST_DISPATCH)
	`DSS_ASSERT_NEXT(a_count_step, 1'b1, count_q == $past(count_q) || count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1))
	`DSS_ASSERT_NOW(a_rsp_source, $rose(rsp_valid_q), $past(state_q) == ST_FINISH)

endmodule

// File: dv/tb_dedup_set_store.sv
// Self-checking testbench for dedup_set_store: insert, delete and read words
// are checked against a behavioral copy of the set kept in this file.
// Depends on dss_pkg and the dedup_set_store RTL.
`timescale 1ns / 1ps

module tb_dedup_set_store;
	import dss_pkg::*;

	localparam int SET_CAPACITY = SET_CAPACITY_DEF;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int POOL_SIZE = 20;
	localparam int LONG_HOLD = 300;
	localparam int TAIL_CYCLES = 32;
	localparam int unsigned CYCLE_LIMIT = 800000;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_word_t rsp;

	// Behavioral copy of the store.
	logic signed [31:0] set_entries[SET_CAPACITY];
	int                 set_fill;

	rsp_word_t          pending_rsp[$];
	logic signed [31:0] value_pool[POOL_SIZE];
	int unsigned        burst_left = 0;
	int unsigned        fail_count = 0;
	int unsigned        cycle_count = 0;
	bit                 rsp_hold_req = 1'b0;

	dedup_set_store #(
		.SET_CAPACITY(SET_CAPACITY)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_dedup_set_store failed");
			$finish;
		end
	end

	function automatic rsp_word_t set_apply(req_word_t w);
		rsp_word_t r;
		int        hit;
		r = '0;
		r.status = STATUS_DONE;
		hit = -1;
		for (int p = 0; p < set_fill; p++)
			if (hit < 0 && set_entries[p] == w.value)
				hit = p;
		case (w.kind)
			KIND_INSERT: begin
				if (hit >= 0)
					r.status = STATUS_PRESENT;
				else if (set_fill >= SET_CAPACITY)
					r.status = STATUS_FULL;
				else begin
					set_entries[set_fill] = w.value;
					set_fill++;
				end
			end
			KIND_DELETE: begin
				if (hit < 0)
					r.status = STATUS_ABSENT;
				else begin
					// Later entries slide down one place to keep insertion order.
					for (int p = hit; p < set_fill - 1; p++)
						set_entries[p] = set_entries[p + 1];
					set_fill--;
				end
			end
			KIND_READ: begin
				if (int'(w.index) >= set_fill)
					r.status = STATUS_RANGE;
				else
					r.element = set_entries[w.index];
			end
			default: begin
			end
		endcase
		r.element_count = 5'(set_fill);
		return r;
	endfunction

	function automatic req_word_t make_word(logic [1:0] kind, logic signed [31:0] value,
			logic [3:0] index);
		req_word_t w;
		w.kind = kind;
		w.value = value;
		w.index = index;
		return w;
	endfunction

	// Offers one word, inserting a random gap at the start of each burst.
	task automatic send_word(req_word_t w);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		pending_rsp.push_back(set_apply(w));
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	task automatic test_basic_ops();
		send_word(make_word(KIND_READ, 32'sd0, 4'd0));
		send_word(make_word(KIND_INSERT, VAL_MIN, 4'd0));
		send_word(make_word(KIND_INSERT, VAL_MAX, 4'd0));
		send_word(make_word(KIND_INSERT, 32'sd0, 4'd0));
		send_word(make_word(KIND_INSERT, -32'sd1, 4'd0));
		send_word(make_word(KIND_INSERT, VAL_MAX, 4'd0));
		send_word(make_word(KIND_READ, 32'sd0, 4'd1));
		send_word(make_word(KIND_READ, 32'sd0, 4'd4));
		send_word(make_word(KIND_UNUSED, 32'sh5a5a_a5a5, 4'd9));
		send_word(make_word(KIND_DELETE, 32'sd0, 4'd0));
		send_word(make_word(KIND_DELETE, 32'sd5, 4'd0));
	endtask

	task automatic test_full_store();
		for (int i = 0; i < 13; i++)
			send_word(make_word(KIND_INSERT, 32'sh1234_5600 + i, 4'd0));
		send_word(make_word(KIND_INSERT, 32'sh7654_3210, 4'd0));
		// A value already present must report present even with the store full.
		send_word(make_word(KIND_INSERT, VAL_MIN, 4'd0));
		send_word(make_word(KIND_READ, 32'sd0, 4'd15));
		send_word(make_word(KIND_DELETE, VAL_MIN, 4'd0));
		send_word(make_word(KIND_DELETE, 32'sh1234_560c, 4'd0));
		send_word(make_word(KIND_READ, 32'sd0, 4'd13));
	endtask

	// The receiver stalls for a long stretch while words keep coming, so the
	// block fills its output register and then holds off its input.
	task automatic test_rsp_backpressure();
		req_word_t w;
		rsp_hold_req = 1'b1;
		for (int i = 0; i < 12; i++) begin
			w.kind = ($urandom_range(0, 1) == 0) ? KIND_INSERT : KIND_READ;
			w.value = $urandom;
			w.index = 4'($urandom_range(0, 15));
			send_word(w);
		end
	endtask

	task automatic test_random_traffic(int unsigned n_items);
		int unsigned sent;
		int unsigned phase_left;
		int unsigned ins_pct;
		int unsigned roll;
		req_word_t   w;
		sent = 0;
		phase_left = 0;
		ins_pct = 50;
		value_pool[0] = VAL_MIN;
		value_pool[1] = VAL_MAX;
		value_pool[2] = 32'sd0;
		value_pool[3] = -32'sd1;
		for (int i = 4; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;
		while (sent < n_items) begin
			// Phases lean toward filling or draining so the count sweeps its range.
			if (phase_left == 0) begin
				phase_left = $urandom_range(40, 160);
				case ($urandom_range(0, 2))
					0: ins_pct = 75;
					1: ins_pct = 25;
					default: ins_pct = 45;
				endcase
				if ($urandom_range(0, 3) == 0)
					value_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;
			end
			phase_left--;
			roll = $urandom_range(0, 99);
			w.value = ($urandom_range(0, 6) == 0) ? $urandom :
				value_pool[$urandom_range(0, POOL_SIZE - 1)];
			if ($urandom_range(0, 3) == 0 || set_fill == 0)
				w.index = 4'($urandom_range(0, 15));
			else
				w.index = 4'($urandom_range(0, set_fill - 1));
			if (roll < 3)
				w.kind = KIND_UNUSED;
			else if (roll < 23)
				w.kind = KIND_READ;
			else if ($urandom_range(0, 99) < ins_pct)
				w.kind = KIND_INSERT;
			else
				w.kind = KIND_DELETE;
			send_word(w);
			if (w.kind != KIND_UNUSED)
				sent++;
		end
	endtask

	// Receiver: ready pattern changes in phases; a long hold when requested.
	initial begin
		int unsigned mode;
		int unsigned phase_left;
		mode = 0;
		phase_left = 0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_req) begin
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
				rsp_hold_req = 1'b0;
			end else begin
				if (phase_left == 0) begin
					mode = $urandom_range(0, 2);
					phase_left = $urandom_range(16, 120);
				end
				phase_left--;
				case (mode)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= 1'($urandom_range(0, 1));
					default: rsp_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : chk_rsp
		rsp_word_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$error("response word with none expected: status %0d count %0d element %0d",
					rsp.status, rsp.element_count, rsp.element);
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					fail_count++;
				end
				if (rsp.element_count !== want.element_count) begin
					$error("element_count: expected %0d, got %0d", want.element_count,
						rsp.element_count);
					fail_count++;
				end
				if (rsp.element !== want.element) begin
					$error("element: expected %0d, got %0d", want.element, rsp.element);
					fail_count++;
				end
			end
		end
	end

	initial begin
		set_fill = 0;
		for (int i = 0; i < SET_CAPACITY; i++)
			set_entries[i] = '0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		wait_drained();
		test_full_store();
		wait_drained();
		test_rsp_backpressure();
		wait_drained();
		test_random_traffic(1300);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("tb_dedup_set_store passed");
		else
			$display("tb_dedup_set_store failed");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/dss_pkg.sv
rtl/dss_ram.sv
rtl/dedup_set_store.sv
dv/tb_dedup_set_store.sv
